// File: sv/bchd_pkg.sv
// package: shared constants and types for the button click and hold detector
package bchd_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int CNT_WIDTH  = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_WIDTH-1:0] COUNT_CAP = CNT_WIDTH'(60000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEPS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS_STEPS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP_STEPS = 2'd3;

  // register reset values
  localparam logic [CFG_WIDTH-1:0] RST_UPDATE_INTERVAL = 16'd10;
  localparam logic [CFG_WIDTH-1:0] RST_HOLD_STEPS      = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] RST_MIN_PRESS_STEPS = 16'd3;
  localparam logic [CFG_WIDTH-1:0] RST_CLICK_GAP_STEPS = 16'd30;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_HOLD   = 2'd3;

  typedef logic [1:0] event_t;

endpackage

// File: sv/button_click_hold_detector.sv
// top level: button single, double click and hold detector
//
// One transaction in gives exactly one transaction out. Each input transaction
// carries a free-running time stamp and the pin level (0 pressed). An
// evaluation step runs only when the time stamp has advanced by at least
// update_interval ticks (modulo 2^TIME_WIDTH) since the last step; the
// result reports whether the step ran and any event it raised: single, double
// or hold. The block takes one transaction per cycle while the output side
// keeps taking results: the whole step is evaluated in the accepting cycle and
// lands in the result register, so its result is valid in the next cycle.
// The result register holds a finished result under back-pressure and the
// input is accepted again in the cycle that result is taken. Configuration
// registers are written through the cfg port with no handshake; writes
// should be made while the block is idle.
module button_click_hold_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bchd_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bchd_pkg::TIME_WIDTH-1:0]     in_time_stamp,
  input  logic                                in_pin_level,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_res,
  output logic                                out_stepped
);

  // configuration registers
  logic [bchd_pkg::CFG_WIDTH-1:0] update_interval_r;
  logic [bchd_pkg::CFG_WIDTH-1:0] hold_steps_r;
  logic [bchd_pkg::CFG_WIDTH-1:0] min_press_steps_r;
  logic [bchd_pkg::CFG_WIDTH-1:0] click_gap_steps_r;

  // detector state
  logic [bchd_pkg::TIME_WIDTH-1:0] last_step_time_r, last_step_time_nxt;
  logic [bchd_pkg::CNT_WIDTH-1:0]  press_count_r, press_count_nxt;
  logic [bchd_pkg::CNT_WIDTH-1:0]  release_count_r, release_count_nxt;
  logic [1:0]                      clicks_seen_r, clicks_seen_nxt;

  // result register
  logic                  out_valid_r;
  bchd_pkg::event_t      event_r, event_nxt;
  logic                  stepped_r, stepped_nxt;

  logic                            in_accept;
  logic [bchd_pkg::TIME_WIDTH-1:0] elapsed;
  logic                            step_due;
  logic                            pressed;

  // result register frees up when empty or being taken this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign out_valid     = out_valid_r;
  assign out_event_res = event_r;
  assign out_stepped   = stepped_r;

  // wrapping difference, compared against the zero-extended interval
  assign elapsed  = in_time_stamp - last_step_time_r;
  assign step_due = elapsed >= bchd_pkg::TIME_WIDTH'(update_interval_r);
  assign pressed  = !in_pin_level;

  // one evaluation step
  always_comb begin
    last_step_time_nxt = last_step_time_r;
    press_count_nxt    = press_count_r;
    release_count_nxt  = release_count_r;
    clicks_seen_nxt    = clicks_seen_r;
    event_nxt          = bchd_pkg::EV_NONE;
    stepped_nxt        = 1'b0;

    if (step_due) begin
      stepped_nxt        = 1'b1;
      last_step_time_nxt = in_time_stamp;
      if (pressed) begin
        release_count_nxt = '0;
        // press count saturates at the cap
        if (press_count_r < bchd_pkg::COUNT_CAP) begin
          press_count_nxt = press_count_r + 1'b1;
        end
        // hold drops any pending click; a zero or out-of-range limit never matches
        if (press_count_nxt == hold_steps_r) begin
          event_nxt       = bchd_pkg::EV_HOLD;
          clicks_seen_nxt = '0;
        end
      end else begin
        // release: a press of the right length counts as a click
        if (press_count_r != '0) begin
          if (press_count_r > min_press_steps_r && press_count_r < hold_steps_r &&
              clicks_seen_r != 2'd3) begin
            clicks_seen_nxt = clicks_seen_r + 1'b1;
          end
          press_count_nxt = '0;
        end
        if (clicks_seen_nxt != '0) begin
          if (release_count_r < bchd_pkg::COUNT_CAP) begin
            release_count_nxt = release_count_r + 1'b1;
          end
          if (clicks_seen_nxt == 2'd2) begin
            event_nxt         = bchd_pkg::EV_DOUBLE;
            clicks_seen_nxt   = '0;
            release_count_nxt = '0;
          end else if (release_count_nxt > click_gap_steps_r) begin
            // gap ran out; only a lone click reports single
            if (clicks_seen_nxt == 2'd1) begin
              event_nxt = bchd_pkg::EV_SINGLE;
            end
            clicks_seen_nxt   = '0;
            release_count_nxt = '0;
          end
        end else begin
          release_count_nxt = '0;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      update_interval_r <= bchd_pkg::RST_UPDATE_INTERVAL;
      hold_steps_r      <= bchd_pkg::RST_HOLD_STEPS;
      min_press_steps_r <= bchd_pkg::RST_MIN_PRESS_STEPS;
      click_gap_steps_r <= bchd_pkg::RST_CLICK_GAP_STEPS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bchd_pkg::REG_UPDATE_INTERVAL: update_interval_r <= cfg_wdata;
        bchd_pkg::REG_HOLD_STEPS:      hold_steps_r      <= cfg_wdata;
        bchd_pkg::REG_MIN_PRESS_STEPS: min_press_steps_r <= cfg_wdata;
        bchd_pkg::REG_CLICK_GAP_STEPS: click_gap_steps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // detector state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_step_time_r <= '0;
      press_count_r    <= '0;
      release_count_r  <= '0;
      clicks_seen_r    <= '0;
    end else if (in_accept) begin
      last_step_time_r <= last_step_time_nxt;
      press_count_r    <= press_count_nxt;
      release_count_r  <= release_count_nxt;
      clicks_seen_r    <= clicks_seen_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      event_r   <= event_nxt;
      stepped_r <= stepped_nxt;
    end
  end

endmodule

// File: sv/bchd_checker.sv
// checker: port-level assertions for the button click and hold detector, with bind
module bchd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_pin_level,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_event_res,
  input logic                            out_stepped
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_res) &&
                                   $stable(out_stepped)))
    else $error("stalled result changed");

  // an empty result register never refuses a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while result register empty");

  // every accepted transaction shows up as a result next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted transaction produced no result");

  // an event is only raised by a step that ran
  a_event_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != bchd_pkg::EV_NONE) |-> out_stepped)
    else $error("event without a step");

  // click events only come from released samples
  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_pin_level) |=>
      (out_event_res != bchd_pkg::EV_SINGLE && out_event_res != bchd_pkg::EV_DOUBLE))
    else $error("click event on a pressed sample");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_pin_level  (in_pin_level),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .out_stepped   (out_stepped)
);
